/* rtl/vvsf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the voxel vote surface filter.
package vvsf_pkg;

	localparam int GRID_SIZE   = 64;
	localparam int COORD_W     = 6;
	localparam int VOTE_W      = 16;
	localparam int LIMIT_W     = 5;
	localparam int CNT_W       = 5;
	localparam int ROWS        = GRID_SIZE * GRID_SIZE;
	localparam int ROW_AW      = $clog2(ROWS);
	localparam int STEPS       = 9;
	localparam int STEP_W      = $clog2(STEPS);
	localparam int CMDQ_DEPTH  = 4;
	localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
	localparam int RESQ_DEPTH  = 2;
	localparam int RESQ_AW     = $clog2(RESQ_DEPTH);

	localparam logic [STEP_W-1:0] FIRST_STEP  = STEP_W'(0);
	localparam logic [STEP_W-1:0] CENTER_STEP = STEP_W'(4);
	localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(STEPS - 1);

	localparam logic [VOTE_W-1:0]  VOTES_RESET = VOTE_W'(1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(18);

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic {
		REG_REQUIRED_VOTES  = 1'b0,
		REG_NEIGHBOUR_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_PUSH
	} back_state_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		kind_t              kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               occ;
		logic               in_grid;
		logic               interior;
	} cmd_t;

	function automatic logic coord_in_grid(input logic [COORD_W-1:0] c);
		return int'(c) < GRID_SIZE;
	endfunction

	function automatic logic coord_interior(input logic [COORD_W-1:0] c);
		return (int'(c) >= 1) && (int'(c) + 2 <= GRID_SIZE);
	endfunction

	// Neighbour walk: step s visits x offset s/3 and y offset s%3, coded 0..2 for -1..+1.
	function automatic logic [1:0] step_dx(input logic [STEP_W-1:0] s);
		logic [1:0] d;
		case (s)
			4'd0, 4'd1, 4'd2: d = 2'd0;
			4'd3, 4'd4, 4'd5: d = 2'd1;
			default:          d = 2'd2;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] step_dy(input logic [STEP_W-1:0] s);
		logic [1:0] d;
		case (s)
			4'd0, 4'd3, 4'd6: d = 2'd0;
			4'd1, 4'd4, 4'd7: d = 2'd1;
			default:          d = 2'd2;
		endcase
		return d;
	endfunction

	function automatic logic [COORD_W-1:0] offset_coord(input logic [COORD_W-1:0] c,
			input logic [1:0] off);
		return c + COORD_W'(off) - COORD_W'(1);
	endfunction

	function automatic logic [ROW_AW-1:0] row_addr(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		return ROW_AW'(int'(x) * GRID_SIZE + int'(y));
	endfunction

endpackage

/* rtl/vvsf_front.sv */
`timescale 1ns / 1ps
// Front part: accepts items, classifies them and holds them in a short command queue.
module vvsf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         kind,
	input  logic [vvsf_pkg::COORD_W-1:0] x_coord,
	input  logic [vvsf_pkg::COORD_W-1:0] y_coord,
	input  logic [vvsf_pkg::COORD_W-1:0] z_coord,
	input  logic [vvsf_pkg::VOTE_W-1:0]  vote_count,
	input  logic [vvsf_pkg::VOTE_W-1:0]  required_votes,
	input  logic                         clearing,
	output logic                         cmd_valid,
	output vvsf_pkg::cmd_t               cmd,
	input  logic                         cmd_pop
);

	vvsf_pkg::cmd_t                   cmdq_q [vvsf_pkg::CMDQ_DEPTH];
	logic [vvsf_pkg::CMDQ_AW-1:0]     wr_ptr_q;
	logic [vvsf_pkg::CMDQ_AW-1:0]     rd_ptr_q;
	logic [vvsf_pkg::CMDQ_AW:0]       count_q;
	logic                             accept;
	logic                             do_pop;
	vvsf_pkg::cmd_t                   new_cmd;

	assign full      = (count_q == (vvsf_pkg::CMDQ_AW + 1)'(vvsf_pkg::CMDQ_DEPTH)) || clearing;
	assign accept    = push && !full;
	assign cmd_valid = (count_q != '0);
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = cmdq_q[rd_ptr_q];

	// Occupancy is decided here; the user must change the registers only while the block is idle (not enforced).
	always_comb begin
		new_cmd.kind     = vvsf_pkg::kind_t'(kind);
		new_cmd.x        = x_coord;
		new_cmd.y        = y_coord;
		new_cmd.z        = z_coord;
		new_cmd.occ      = (vote_count == required_votes);
		new_cmd.in_grid  = vvsf_pkg::coord_in_grid(x_coord) && vvsf_pkg::coord_in_grid(y_coord)
			&& vvsf_pkg::coord_in_grid(z_coord);
		new_cmd.interior = vvsf_pkg::coord_interior(x_coord)
			&& vvsf_pkg::coord_interior(y_coord) && vvsf_pkg::coord_interior(z_coord);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmdq_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + vvsf_pkg::CMDQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + vvsf_pkg::CMDQ_AW'(1);
			end
			if (accept && !do_pop) begin
				count_q <= count_q + (vvsf_pkg::CMDQ_AW + 1)'(1);
			end else if (!accept && do_pop) begin
				count_q <= count_q - (vvsf_pkg::CMDQ_AW + 1)'(1);
			end
		end
	end

endmodule

/* rtl/vvsf_back.sv */
`timescale 1ns / 1ps
// Back part: grid memory, clearing pass, voxel writes and the neighbour query sequencer.
module vvsf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  vvsf_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          clearing,
	input  logic [vvsf_pkg::LIMIT_W-1:0]  neighbour_limit,
	input  logic                          res_full,
	output logic                          res_push,
	output logic                          res_bit
);

	// One row holds all z positions of one (x, y) column.
	logic [vvsf_pkg::GRID_SIZE-1:0] grid_mem [vvsf_pkg::ROWS];

	vvsf_pkg::back_state_t            state_q;
	vvsf_pkg::back_state_t            state_d;
	logic [vvsf_pkg::ROW_AW-1:0]      clr_addr_q;
	vvsf_pkg::cmd_t                   cmd_q;
	logic [vvsf_pkg::STEP_W-1:0]      step_q;
	logic [vvsf_pkg::CNT_W-1:0]       cnt_q;
	logic                             center_q;
	logic [vvsf_pkg::STEP_W-1:0]      step_s1;
	logic                             rvalid_s1;
	logic [vvsf_pkg::GRID_SIZE-1:0]   rd_row_s1;

	logic [vvsf_pkg::ROW_AW-1:0]      mem_addr;
	logic                             mem_we;
	logic                             mem_re;
	logic [vvsf_pkg::GRID_SIZE-1:0]   mem_mask;
	logic [vvsf_pkg::GRID_SIZE-1:0]   mem_wdata;
	logic                             start_query;

	logic [vvsf_pkg::COORD_W-1:0]     rd_x;
	logic [vvsf_pkg::COORD_W-1:0]     rd_y;
	logic [vvsf_pkg::COORD_W-1:0]     acc_x;
	logic [vvsf_pkg::COORD_W-1:0]     acc_y;
	logic [vvsf_pkg::COORD_W-1:0]     z_lo;
	logic [vvsf_pkg::COORD_W-1:0]     z_hi;
	logic                             row_ok;
	logic                             hit_lo;
	logic                             hit_mid;
	logic                             hit_hi;

	assign clearing = (state_q == vvsf_pkg::ST_CLEAR);

	assign rd_x = vvsf_pkg::offset_coord(cmd_q.x, vvsf_pkg::step_dx(step_q));
	assign rd_y = vvsf_pkg::offset_coord(cmd_q.y, vvsf_pkg::step_dy(step_q));

	always_comb begin
		state_d     = state_q;
		mem_addr    = vvsf_pkg::row_addr(rd_x, rd_y);
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_mask    = '0;
		mem_wdata   = '0;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res_bit     = 1'b0;
		start_query = 1'b0;
		unique case (state_q)
			vvsf_pkg::ST_CLEAR: begin
				mem_addr = clr_addr_q;
				mem_we   = 1'b1;
				mem_mask = '1;
				if (clr_addr_q == vvsf_pkg::ROW_AW'(vvsf_pkg::ROWS - 1)) begin
					state_d = vvsf_pkg::ST_IDLE;
				end
			end
			vvsf_pkg::ST_IDLE: begin
				mem_addr = vvsf_pkg::row_addr(cmd.x, cmd.y);
				if (cmd_valid) begin
					if (cmd.kind == vvsf_pkg::KIND_WRITE) begin
						cmd_pop   = 1'b1;
						mem_we    = cmd.in_grid;
						mem_mask[cmd.z] = 1'b1;
						mem_wdata = {vvsf_pkg::GRID_SIZE{cmd.occ}};
					end else if (!res_full) begin
						cmd_pop = 1'b1;
						if (cmd.in_grid) begin
							start_query = 1'b1;
							state_d     = vvsf_pkg::ST_READ;
						end else begin
							res_push = 1'b1;
						end
					end
				end
			end
			vvsf_pkg::ST_READ: begin
				mem_re = 1'b1;
				if (step_q == vvsf_pkg::LAST_STEP || !cmd_q.interior) begin
					state_d = vvsf_pkg::ST_LAST;
				end
			end
			vvsf_pkg::ST_LAST: begin
				state_d = vvsf_pkg::ST_PUSH;
			end
			vvsf_pkg::ST_PUSH: begin
				res_push = 1'b1;
				res_bit  = cmd_q.interior ? (center_q && (cnt_q < neighbour_limit)) : center_q;
				state_d  = vvsf_pkg::ST_IDLE;
			end
			default: begin
				state_d = vvsf_pkg::ST_IDLE;
			end
		endcase
	end

	// Grid memory: one row address per cycle, per-bit write enables, registered read data.
	always_ff @(posedge clk) begin
		for (int i = 0; i < vvsf_pkg::GRID_SIZE; i++) begin
			if (mem_we && mem_mask[i]) begin
				grid_mem[mem_addr][i] <= mem_wdata[i];
			end
		end
		if (mem_re) begin
			rd_row_s1 <= grid_mem[mem_addr];
		end
	end

	// Neighbour bits of the row read in the previous cycle.
	assign acc_x   = vvsf_pkg::offset_coord(cmd_q.x, vvsf_pkg::step_dx(step_s1));
	assign acc_y   = vvsf_pkg::offset_coord(cmd_q.y, vvsf_pkg::step_dy(step_s1));
	assign z_lo    = cmd_q.z - vvsf_pkg::COORD_W'(1);
	assign z_hi    = cmd_q.z + vvsf_pkg::COORD_W'(1);
	assign row_ok  = cmd_q.interior && vvsf_pkg::coord_interior(acc_x)
		&& vvsf_pkg::coord_interior(acc_y);
	assign hit_lo  = row_ok && vvsf_pkg::coord_interior(z_lo) && rd_row_s1[z_lo];
	assign hit_mid = row_ok && (step_s1 != vvsf_pkg::CENTER_STEP) && rd_row_s1[cmd_q.z];
	assign hit_hi  = row_ok && vvsf_pkg::coord_interior(z_hi) && rd_row_s1[z_hi];

	always_ff @(posedge clk) begin
		if (start_query) begin
			cmd_q    <= cmd;
			step_q   <= cmd.interior ? vvsf_pkg::FIRST_STEP : vvsf_pkg::CENTER_STEP;
			cnt_q    <= '0;
			center_q <= 1'b0;
		end else begin
			if (state_q == vvsf_pkg::ST_READ) begin
				step_q  <= step_q + vvsf_pkg::STEP_W'(1);
			end
			if (rvalid_s1) begin
				cnt_q <= cnt_q + vvsf_pkg::CNT_W'(hit_lo) + vvsf_pkg::CNT_W'(hit_mid)
					+ vvsf_pkg::CNT_W'(hit_hi);
				if (step_s1 == vvsf_pkg::CENTER_STEP) begin
					center_q <= rd_row_s1[cmd_q.z];
				end
			end
		end
		step_s1 <= step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vvsf_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			rvalid_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= mem_re;
			if (state_q == vvsf_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + vvsf_pkg::ROW_AW'(1);
			end
		end
	end

endmodule

/* rtl/vvsf_resq.sv */
`timescale 1ns / 1ps
// Result queue: holds finished surface bits until the consumer takes them.
module vvsf_resq (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic wr_bit,
	output logic full,
	input  logic pop,
	output logic empty,
	output logic rd_bit
);

	logic                          slot_q [vvsf_pkg::RESQ_DEPTH];
	logic [vvsf_pkg::RESQ_AW-1:0]  wr_ptr_q;
	logic [vvsf_pkg::RESQ_AW-1:0]  rd_ptr_q;
	logic [vvsf_pkg::RESQ_AW:0]    count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full   = (count_q == (vvsf_pkg::RESQ_AW + 1)'(vvsf_pkg::RESQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = pop && !empty;
	assign rd_bit = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + vvsf_pkg::RESQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + vvsf_pkg::RESQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (vvsf_pkg::RESQ_AW + 1)'(1);
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - (vvsf_pkg::RESQ_AW + 1)'(1);
			end
		end
	end

endmodule

/* rtl/voxel_vote_surface_filter.sv */
`timescale 1ns / 1ps
// Top level of the voxel vote surface filter: configuration registers and the three parts.
//
//   Channel   Direction  Handshake                      Payload
//   items     in         push / full                    kind, x_coord, y_coord, z_coord,
//                                                       vote_count
//   results   out        empty / pop                    surface_bit
//   config    in         cfg_we (no wait)               cfg_index, cfg_data
//
// A write item is written to the grid straight from the idle state. A query of an interior
// voxel makes nine row reads of the single-port grid memory (one (x, y) column per read, the z
// neighbours come out of the same row), then waits for the last registered row and hands the
// result over. A query of a boundary voxel reads only its own row, one outside the grid none.
// After reset the back part clears the grid one row per cycle, all 4096 rows, and full stays
// high during that pass. A four-entry command queue lets the front keep taking items while
// the back works, and a two-entry result queue lets the back finish while the consumer stalls.
module voxel_vote_surface_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         kind,
	input  logic [vvsf_pkg::COORD_W-1:0] x_coord,
	input  logic [vvsf_pkg::COORD_W-1:0] y_coord,
	input  logic [vvsf_pkg::COORD_W-1:0] z_coord,
	input  logic [vvsf_pkg::VOTE_W-1:0]  vote_count,
	output logic                         empty,
	input  logic                         pop,
	output logic                         surface_bit,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [vvsf_pkg::VOTE_W-1:0]  cfg_data
);

	logic [vvsf_pkg::VOTE_W-1:0]  required_votes_q;
	logic [vvsf_pkg::LIMIT_W-1:0] neighbour_limit_q;
	logic                         clearing;
	logic                         cmd_valid;
	vvsf_pkg::cmd_t               cmd;
	logic                         cmd_pop;
	logic                         res_full;
	logic                         res_push;
	logic                         res_bit;

	// Configuration writes land at once; the limit keeps only its low five bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_votes_q  <= vvsf_pkg::VOTES_RESET;
			neighbour_limit_q <= vvsf_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (vvsf_pkg::reg_idx_t'(cfg_index))
				vvsf_pkg::REG_REQUIRED_VOTES:  required_votes_q  <= cfg_data;
				vvsf_pkg::REG_NEIGHBOUR_LIMIT: neighbour_limit_q <= cfg_data[vvsf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// The front decides occupancy for writes and classifies each voxel as it arrives.
	vvsf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.x_coord        (x_coord),
		.y_coord        (y_coord),
		.z_coord        (z_coord),
		.vote_count     (vote_count),
		.required_votes (required_votes_q),
		.clearing       (clearing),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	// The back owns the grid; commands leave it in order, so results keep item order.
	vvsf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.clearing        (clearing),
		.neighbour_limit (neighbour_limit_q),
		.res_full        (res_full),
		.res_push        (res_push),
		.res_bit         (res_bit)
	);

	vvsf_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_bit (res_bit),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rd_bit (surface_bit)
	);

endmodule

/* rtl/vvsf_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the voxel vote surface filter, bound to the top level.
module vvsf_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         full,
	input  logic                         kind,
	input  logic [vvsf_pkg::COORD_W-1:0] x_coord,
	input  logic [vvsf_pkg::COORD_W-1:0] y_coord,
	input  logic [vvsf_pkg::COORD_W-1:0] z_coord,
	input  logic [vvsf_pkg::VOTE_W-1:0]  vote_count,
	input  logic                         empty,
	input  logic                         pop,
	input  logic                         surface_bit,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [vvsf_pkg::VOTE_W-1:0]  cfg_data
);

	// The grid is being cleared right after reset, so no item may be taken then.
	a_full_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> full)
		else $error("full low in the first cycle after reset");

	// Reset empties the result queue; the cycle after a reset edge shows no result.
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result waiting during reset");

	// A waiting result stays until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result vanished without a transfer");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(surface_bit))
		else $error("surface_bit changed while waiting");

endmodule

bind voxel_vote_surface_filter vvsf_checker u_vvsf_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the voxel vote surface filter, run against an occupancy grid model.
module tb_top;
	import vvsf_pkg::*;

	// One item as it is offered on the input side of the block.
	typedef struct packed {
		kind_t              kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [VOTE_W-1:0]  votes;
	} voxel_item_t;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 165;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 40;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                push       = 1'b0;
	logic                full;
	logic                kind       = KIND_WRITE;
	logic [COORD_W-1:0]  x_coord    = '0;
	logic [COORD_W-1:0]  y_coord    = '0;
	logic [COORD_W-1:0]  z_coord    = '0;
	logic [VOTE_W-1:0]   vote_count = '0;
	logic                empty;
	logic                pop        = 1'b0;
	logic                surface_bit;
	logic                cfg_we     = 1'b0;
	logic                cfg_index  = REG_REQUIRED_VOTES;
	logic [VOTE_W-1:0]   cfg_data   = '0;

	voxel_vote_surface_filter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.vote_count  (vote_count),
		.empty       (empty),
		.pop         (pop),
		.surface_bit (surface_bit),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	// Our own copy of the block's state: the occupancy grid and both registers.
	bit                 voxel_map [GRID_SIZE * GRID_SIZE * GRID_SIZE];
	logic [VOTE_W-1:0]  votes_needed  = VOTES_RESET;
	logic [LIMIT_W-1:0] neighbour_cap = LIMIT_RESET;

	voxel_item_t pending_items [$];
	bit          surface_expect [$];

	int items_queued    = 0;
	int items_accepted  = 0;
	int writes_seen     = 0;
	int queries_seen    = 0;
	int kept_seen       = 0;
	int dropped_seen    = 0;
	int mismatches      = 0;
	bit handed_over     = 1'b0;

	// Idle rates in percent, and the receiver hold-off handshake between the sequence and
	// the pop driver. The hold-off itself is counted down inside the pop driver.
	int send_idle_pct   = 0;
	int rx_stall_pct    = 0;
	int hold_requests   = 0;
	int hold_served     = 0;
	int hold_left       = 0;

	logic [VOTE_W-1:0]  phase_votes [PHASES] = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd0,
		16'd7, 16'd1, 16'h8000, 16'd0, 16'd2};
	logic [LIMIT_W-1:0] phase_cap [PHASES] = '{5'd18, 5'd0, 5'd27, 5'd31, 5'd9,
		5'd13, 5'd4, 5'd22, 5'd0, 5'd26};

	function automatic int voxel_index(input int x, input int y, input int z);
		return (x * GRID_SIZE + y) * GRID_SIZE + z;
	endfunction

	function automatic bit is_inner(input int c);
		return c >= 1 && c <= GRID_SIZE - 2;
	endfunction

	// Filtered value of one voxel. Boundary voxels report their stored bit. An occupied
	// interior voxel survives only while its occupied interior neighbours stay under the cap;
	// occupied boundary neighbours do not count.
	function automatic bit surface_of(input int x, input int y, input int z);
		int crowd;
		crowd = 0;
		if (!is_inner(x) || !is_inner(y) || !is_inner(z))
			return voxel_map[voxel_index(x, y, z)];
		if (!voxel_map[voxel_index(x, y, z)])
			return 1'b0;
		for (int dx = -1; dx <= 1; dx++)
			for (int dy = -1; dy <= 1; dy++)
				for (int dz = -1; dz <= 1; dz++)
					if ((dx != 0 || dy != 0 || dz != 0) && is_inner(x + dx) &&
							is_inner(y + dy) && is_inner(z + dz) &&
							voxel_map[voxel_index(x + dx, y + dy, z + dz)])
						crowd++;
		return crowd < int'(neighbour_cap);
	endfunction

	// Result side first, then the input side, so that a result and a new query in the same
	// cycle are never paired with each other. Both handshakes are judged on the values that
	// were present just before the edge.
	always @(posedge clk) begin
		bit want;
		handed_over = 1'b0;
		if (arst_n) begin
			if (pop && !empty) begin
				if (surface_expect.size() == 0) begin
					$error("surface_bit: no query waiting, got %0b", surface_bit);
					mismatches++;
				end else begin
					want = surface_expect.pop_front();
					if (surface_bit !== want) begin
						$error("surface_bit: expected %0b, actual %0b", want, surface_bit);
						mismatches++;
					end
					if (want)
						kept_seen++;
					else
						dropped_seen++;
				end
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_REQUIRED_VOTES:  votes_needed = cfg_data;
					REG_NEIGHBOUR_LIMIT: neighbour_cap = cfg_data[LIMIT_W-1:0];
				endcase
			end
			if (push && !full) begin
				handed_over = 1'b1;
				items_accepted++;
				// The vote comparison is plain equality, so a required count of zero
				// makes a zero-vote write mark the voxel.
				if (kind == KIND_WRITE) begin
					voxel_map[voxel_index(x_coord, y_coord, z_coord)] =
						(vote_count == votes_needed);
					writes_seen++;
				end else begin
					surface_expect = {surface_expect, surface_of(x_coord, y_coord, z_coord)};
					queries_seen++;
				end
			end
		end
	end

	// Item driver: a new item is offered only once the previous one made its transfer.
	always @(negedge clk) begin
		voxel_item_t next_item;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || handed_over) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				push <= 1'b1;
				kind <= next_item.kind;
				x_coord <= next_item.x;
				y_coord <= next_item.y;
				z_coord <= next_item.z;
				vote_count <= next_item.votes;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result driver: random stalls, plus a long hold-off whenever the sequence asks for one.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic queue_item(input kind_t k, input int x, input int y, input int z,
			input logic [VOTE_W-1:0] votes);
		voxel_item_t it;
		it.kind = k;
		it.x = COORD_W'(x);
		it.y = COORD_W'(y);
		it.z = COORD_W'(z);
		it.votes = votes;
		pending_items = {pending_items, it};
		items_queued++;
	endtask

	// Random items gathered in small boxes, so that neighbourhoods fill up and the neighbour
	// count sweeps across the cap. Each axis of a box sits on the low face, the high face or
	// somewhere inside; one item in ten lands anywhere in the grid.
	task automatic queue_random_items(input int count, input int query_pct);
		int side;
		int lo [3];
		kind_t k;
		logic [VOTE_W-1:0] votes;
		side = 3;
		for (int i = 0; i < count; i++) begin
			if (i % 24 == 0) begin
				side = $urandom_range(3, 5);
				foreach (lo[a]) begin
					case ($urandom_range(2))
						0:       lo[a] = 0;
						1:       lo[a] = GRID_SIZE - side;
						default: lo[a] = $urandom_range(1, GRID_SIZE - 1 - side);
					endcase
				end
			end
			k = ($urandom_range(99) < query_pct) ? KIND_QUERY : KIND_WRITE;
			votes = ($urandom_range(99) < 65) ? votes_needed : VOTE_W'($urandom);
			if ($urandom_range(9) == 0)
				queue_item(k, $urandom_range(GRID_SIZE - 1), $urandom_range(GRID_SIZE - 1),
					$urandom_range(GRID_SIZE - 1), votes);
			else
				queue_item(k, lo[0] + $urandom_range(side - 1), lo[1] + $urandom_range(side - 1),
					lo[2] + $urandom_range(side - 1), votes);
		end
	endtask

	// Wait for every item to make its transfer and every result to come back, then let any
	// trailing writes in the command queue retire before the block counts as idle.
	task automatic drain;
		while (items_accepted != items_queued || surface_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [VOTE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with a cap of one so that a single interior neighbour drops a voxel.
		// The grid clearing pass after reset holds these back until full falls.
		write_reg(REG_REQUIRED_VOTES, 16'd1);
		write_reg(REG_NEIGHBOUR_LIMIT, 16'd1);
		queue_item(KIND_QUERY, 0, 0, 0, 16'd0);
		queue_item(KIND_WRITE, 0, 0, 0, 16'd1);
		queue_item(KIND_QUERY, 0, 0, 0, 16'd0);
		queue_item(KIND_WRITE, 63, 63, 63, 16'd1);
		queue_item(KIND_QUERY, 63, 63, 63, 16'hFFFF);
		queue_item(KIND_WRITE, 63, 63, 63, 16'hFFFF);
		queue_item(KIND_QUERY, 63, 63, 63, 16'd0);
		// An occupied corner next to an interior voxel must not count as a neighbour.
		queue_item(KIND_WRITE, 1, 1, 1, 16'd1);
		queue_item(KIND_QUERY, 1, 1, 1, 16'd0);
		queue_item(KIND_WRITE, 2, 2, 2, 16'd1);
		queue_item(KIND_QUERY, 1, 1, 1, 16'd0);
		queue_item(KIND_QUERY, 2, 2, 2, 16'd0);
		queue_item(KIND_WRITE, 62, 62, 62, 16'd1);
		queue_item(KIND_WRITE, 63, 62, 62, 16'd1);
		queue_item(KIND_QUERY, 62, 62, 62, 16'd0);
		queue_item(KIND_WRITE, 62, 62, 62, 16'd0);
		queue_item(KIND_QUERY, 62, 62, 62, 16'd0);
		queue_item(KIND_WRITE, 42, 21, 42, 16'd1);
		queue_item(KIND_QUERY, 42, 21, 42, 16'hAAAA);
		queue_item(KIND_QUERY, 21, 42, 21, 16'd0);
		queue_item(KIND_WRITE, 42, 21, 42, 16'h5555);
		queue_item(KIND_QUERY, 42, 21, 42, 16'd0);
		drain();

		phase_votes[4] = VOTE_W'($urandom);
		phase_votes[8] = VOTE_W'($urandom_range(1, 65535));
		phase_cap[8] = LIMIT_W'($urandom_range(27));

		// Random phases: both registers change every phase while the block is idle, and the
		// idle pattern rotates through none, sender only, receiver only and both.
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_REQUIRED_VOTES, phase_votes[p]);
			write_reg(REG_NEIGHBOUR_LIMIT, VOTE_W'(phase_cap[p]));
			case (p % 4)
				0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin send_idle_pct = 84; rx_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rx_stall_pct = 84; end
				default: begin send_idle_pct = 29; rx_stall_pct = 29; end
			endcase
			// In one phase the receiver stops for a long stretch while queries keep coming,
			// so both internal queues fill and full pushes back on the sender.
			if (p == 4) begin
				hold_requests++;
				queue_random_items(PHASE_ITEMS / 2, 85);
			end else begin
				queue_random_items(PHASE_ITEMS / 2, 40);
			end
			// The sender pauses halfway until every result of the first half is back.
			drain();
			queue_random_items(PHASE_ITEMS - PHASE_ITEMS / 2, 40);
			drain();
		end

		if (surface_expect.size() != 0) begin
			$error("surface_bit: %0d results never arrived", surface_expect.size());
			mismatches++;
		end
		$display("Run covered %0d writes and %0d queries over %0d register settings.",
			writes_seen, queries_seen, PHASES + 1);
		$display("Queried voxels kept: %0d, dropped: %0d.", kept_seen, dropped_seen);
		if (mismatches == 0)
			$display("voxel_vote_surface_filter: match");
		else
			$display("voxel_vote_surface_filter: mismatch");
		$finish;
	end

	// Hard stop, far beyond the slowest legal run including the grid clearing pass.
	initial begin
		#6_000_000;
		$display("voxel_vote_surface_filter: mismatch");
		$finish;
	end

endmodule
